// ===== hdl/fletcher32_byte_stream_checksum_core_macros.svh =====
// Assertion macros shared by the checksum core RTL.
`ifndef FLETCHER32_BYTE_STREAM_CHECKSUM_CORE_MACROS_SVH
`define FLETCHER32_BYTE_STREAM_CHECKSUM_CORE_MACROS_SVH

// Same-cycle implication, checked on every edge out of reset.
`define F32_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("checksum core: same-cycle check failed");

// Next-cycle implication, checked on every edge out of reset.
`define F32_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("checksum core: next-cycle check failed");

`endif

// ===== hdl/f32_pkg.sv =====
package f32_pkg;

    localparam int          BLOCK_WORDS = 360;
    localparam int          WIB_W       = 9;
    localparam logic [31:0] SUM_INIT    = 32'h0000_ffff;

    // Sums captured at the end of a message, waiting for the final folds.
    typedef struct packed {
        logic [31:0] sum1;
        logic [31:0] sum2;
        logic        two_folds;
    } t_fin;

    // Add the high half of a sum into its low 16 bits.
    function automatic logic [31:0] fold16(input logic [31:0] v);
        return {16'h0000, v[15:0]} + {16'h0000, v[31:16]};
    endfunction

endpackage

// ===== hdl/fletcher32_byte_stream_checksum_core.sv =====
// Channel  | valid    | ready    | payload
// ---------+----------+----------+------------------------------
// byte in  | i_valid  | o_ready  | i_data_byte, i_last_byte
// sum out  | o_valid  | i_ready  | o_checksum
//
// One byte is taken every cycle while o_ready is high; the sum update is two
// chained 32-bit adds. The checksum of a message passes through the finish
// register and then the fold/output register after its last byte is taken.
// Reset (synchronous, active low) returns both sums to 0xffff and empties
// both stages. A stalled output holds; the finish register then fills and
// o_ready drops only while both stages are full.
module fletcher32_byte_stream_checksum_core
    import f32_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_checksum
);

    `include "fletcher32_byte_stream_checksum_core_macros.svh"

    // Running message state.
    logic [31:0]      r_s1, n_s1;
    logic [31:0]      r_s2, n_s2;
    logic [WIB_W-1:0] r_wib, n_wib;
    logic             r_any, n_any;
    logic             r_pending, n_pending;
    logic [7:0]       r_held, n_held;

    // Finish stage: sums of a completed message.
    logic             r_fin_vld, n_fin_vld;
    t_fin             r_fin, n_fin;
    logic             fin_ready;

    logic             in_fire;
    logic [15:0]      addend;
    logic [31:0]      s1a, s2a;

    assign o_ready = !r_fin_vld || fin_ready;
    assign in_fire = i_valid && o_ready;

    // A full word when a low byte is held, otherwise the lone trailing byte.
    assign addend = r_pending ? {i_data_byte, r_held} : {8'h00, i_data_byte};
    assign s1a    = r_s1 + {16'h0000, addend};
    assign s2a    = r_s2 + s1a;

    always_comb begin
        n_s1      = r_s1;
        n_s2      = r_s2;
        n_wib     = r_wib;
        n_any     = r_any;
        n_pending = r_pending;
        n_held    = r_held;
        n_fin     = r_fin;
        n_fin_vld = r_fin_vld && !fin_ready;

        if (in_fire) begin
            if (i_last_byte) begin
                // Close the message: hand the sums to the finish stage.
                n_fin_vld = 1'b1;
                if (r_pending || r_any) begin
                    n_fin = '{sum1: s1a, sum2: s2a, two_folds: 1'b1};
                end else begin
                    // Single byte, no word seen: sums stay untouched.
                    n_fin = '{sum1: r_s1, sum2: r_s2, two_folds: 1'b0};
                end
                n_s1      = SUM_INIT;
                n_s2      = SUM_INIT;
                n_wib     = '0;
                n_any     = 1'b0;
                n_pending = 1'b0;
            end else if (r_pending) begin
                // High byte completes the word.
                n_s1      = s1a;
                n_s2      = s2a;
                n_wib     = r_wib + 1'b1;
                n_any     = 1'b1;
                n_pending = 1'b0;
            end else begin
                // Low byte of a new word: make the deferred block fold first.
                if (r_wib >= WIB_W'(BLOCK_WORDS)) begin
                    n_s1  = fold16(r_s1);
                    n_s2  = fold16(r_s2);
                    n_wib = '0;
                end
                n_held    = i_data_byte;
                n_pending = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1      <= SUM_INIT;
            r_s2      <= SUM_INIT;
            r_wib     <= '0;
            r_any     <= 1'b0;
            r_pending <= 1'b0;
            r_fin_vld <= 1'b0;
        end else begin
            r_s1      <= n_s1;
            r_s2      <= n_s2;
            r_wib     <= n_wib;
            r_any     <= n_any;
            r_pending <= n_pending;
            r_fin_vld <= n_fin_vld;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        r_fin  <= n_fin;
    end

    f32_fold_out u_fold_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (r_fin_vld),
        .o_fin_ready (fin_ready),
        .i_fin       (r_fin),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_checksum  (o_checksum)
    );

    // Block counter never runs past one block.
    `F32_ASSERT_IMPL(a_wib_range, 1'b1, r_wib <= WIB_W'(BLOCK_WORDS))
    // Last byte leaves a fresh message state and a loaded finish stage.
    `F32_ASSERT_NEXT(a_last_clears, in_fire && i_last_byte, !r_pending && !r_any && r_wib == '0 && r_s1 == SUM_INIT && r_s2 == SUM_INIT && r_fin_vld)
    // A finish entry that is not taken holds.
    `F32_ASSERT_NEXT(a_fin_hold, r_fin_vld && !fin_ready, r_fin_vld && $stable(r_fin))
    // Input stalls only while both stages are full.
    `F32_ASSERT_IMPL(a_ready_full, !o_ready, r_fin_vld && o_valid && !i_ready)

endmodule

// ===== hdl/f32_fold_out.sv =====
module f32_fold_out
    import f32_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fin_valid,
    output logic        o_fin_ready,
    input  t_fin        i_fin,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_checksum
);

    logic        r_vld;
    logic [31:0] r_sum;
    logic        take;
    logic [31:0] f1, f2, c1, c2;

    assign o_fin_ready = !r_vld || i_ready;
    assign take        = i_fin_valid && o_fin_ready;

    // Block fold (when due) followed by the final fold.
    always_comb begin
        f1 = fold16(i_fin.sum1);
        f2 = fold16(i_fin.sum2);
        c1 = i_fin.two_folds ? fold16(f1) : f1;
        c2 = i_fin.two_folds ? fold16(f2) : f2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_sum <= {c2[15:0], 16'h0000} | c1;
        end
    end

    assign o_valid    = r_vld;
    assign o_checksum = r_sum;

endmodule

// ===== sim/fletcher32_byte_stream_checksum_core_test.sv =====
module fletcher32_byte_stream_checksum_core_test;
    import f32_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no word moving on either channel
    localparam int HOLD_CYCLES     = 300;   // long output hold-off to back the core up
    localparam int HOLD_AFTER_SUMS = 12;    // start the hold-off once this many sums came back
    localparam int DRAIN_CYCLES    = 8;     // idle margin after the last expected sum has come back
    localparam int CALM_BYTES      = 200;   // no idling once this few input bytes remain
    localparam int SHORT_BYTES     = 380;   // random short-message stimulus, in bytes
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } t_msg_byte;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_checksum;

    fletcher32_byte_stream_checksum_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_checksum  (o_checksum)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Message bytes waiting to be offered, and checksums waiting to come back.
    t_msg_byte   pending_bytes[$];
    logic [31:0] expected_sums[$];

    // Running checksum state, mirrored from what the core should hold.
    logic [31:0] sum_first;
    logic [31:0] sum_second;
    logic [8:0]  blk_words;      // words added since the last block fold
    logic        word_seen;      // a full word went in during this message
    logic        half_held;      // low byte waiting for its high byte
    logic [7:0]  held_low;

    int mismatches = 0;

    function automatic logic [31:0] fold_high_into_low(input logic [31:0] v);
        return (v & 32'h0000_ffff) + (v >> 16);
    endfunction

    task automatic clear_sums();
        sum_first  = SUM_INIT;
        sum_second = SUM_INIT;
        blk_words  = '0;
        word_seen  = 1'b0;
        half_held  = 1'b0;
        held_low   = 8'h00;
    endtask

    task automatic fold_sums();
        sum_first  = fold_high_into_low(sum_first);
        sum_second = fold_high_into_low(sum_second);
    endtask

    // Fold the last block (only if a word went in), fold once more, emit.
    task automatic close_message();
        if (word_seen)
            fold_sums();
        fold_sums();
        expected_sums.push_back((sum_second << 16) | sum_first);
        clear_sums();
    endtask

    // Advance the mirrored state by one accepted byte.
    task automatic absorb_byte(input logic [7:0] d, input logic is_last);
        if (!half_held) begin
            if (is_last) begin
                // Trailing odd byte counts only after at least one full word;
                // a lone byte leaves both sums at their start value.
                if (word_seen) begin
                    sum_first  = sum_first + {24'h0, d};
                    sum_second = sum_second + sum_first;
                end
                close_message();
            end else begin
                // The fold of a completed block waits for the next word to start.
                if (blk_words >= BLOCK_WORDS) begin
                    fold_sums();
                    blk_words = '0;
                end
                held_low  = d;
                half_held = 1'b1;
            end
        end else begin
            sum_first  = sum_first + {16'h0, d, held_low};
            sum_second = sum_second + sum_first;
            blk_words  = blk_words + 9'd1;
            word_seen  = 1'b1;
            half_held  = 1'b0;
            held_low   = 8'h00;
            if (is_last)
                close_message();
        end
    endtask

    // Queue one message; a negative fill gives random bytes.
    task automatic queue_message(input int len, input int fill);
        t_msg_byte mb;
        for (int k = 0; k < len; k++) begin
            mb.data    = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
            mb.is_last = (k == len - 1);
            pending_bytes.push_back(mb);
        end
    endtask

    // Byte-side driver: offer bytes from the queue, idle in random bursts while
    // plenty remain, and feed the mirrored state with every accepted byte.
    int tx_idle   = 0;
    int tx_words  = 0;
    bit tx_gappy  = 1'b1;

    always @(posedge i_clk) begin : byte_driver
        t_msg_byte nxt;
        logic      offer;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            offer = i_valid;
            if (i_valid && o_ready) begin
                absorb_byte(i_data_byte, i_last_byte);
                tx_words++;
                if (tx_words % 64 == 0)
                    tx_gappy = ($urandom_range(0, 2) != 0);
                offer = 1'b0;
            end
            // Hold an unaccepted byte as it is; otherwise pick the next step.
            if (!offer) begin
                if (tx_idle > 0) begin
                    tx_idle--;
                end else if (pending_bytes.size() != 0) begin
                    if (tx_gappy && pending_bytes.size() > CALM_BYTES &&
                        $urandom_range(0, 5) == 0) begin
                        tx_idle = $urandom_range(1, 18) - 1;
                    end else begin
                        nxt         = pending_bytes.pop_front();
                        offer       = 1'b1;
                        i_data_byte <= nxt.data;
                        i_last_byte <= nxt.is_last;
                    end
                end
            end
            i_valid <= offer;
        end
    end

    // Checksum-side monitor: compare every accepted sum with the oldest one
    // expected, and drive ready with random stalls plus one long hold-off.
    int rx_stall     = 0;
    int rx_hold      = 0;
    int rx_cycles    = 0;
    int sums_checked = 0;
    bit rx_gappy     = 1'b1;
    bit hold_done    = 1'b0;

    always @(posedge i_clk) begin : sum_monitor
        logic [31:0] want;
        logic        take;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                sums_checked++;
                if (expected_sums.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("checksum %h arrived with none expected", o_checksum);
                end else begin
                    want = expected_sums.pop_front();
                    if (o_checksum !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("checksum %0d: expected %h, got %h",
                                     sums_checked, want, o_checksum);
                    end
                end
            end

            rx_cycles++;
            if (rx_cycles % 128 == 0)
                rx_gappy = ($urandom_range(0, 2) != 0);

            // Drop ready for the long hold-off once, then for short bursts
            // while the stimulus is still far from its end.
            take = 1'b1;
            if (rx_hold > 0) begin
                rx_hold--;
                take = 1'b0;
            end else if (!hold_done && sums_checked == HOLD_AFTER_SUMS) begin
                hold_done = 1'b1;
                rx_hold   = HOLD_CYCLES - 1;
                take      = 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                take = 1'b0;
            end else if (rx_gappy && pending_bytes.size() > CALM_BYTES &&
                         $urandom_range(0, 7) == 0) begin
                rx_stall = $urandom_range(1, 18) - 1;
                take     = 1'b0;
            end
            i_ready <= take;
        end
    end

    // Watchdog: stop the run if no word moves on either channel for too long.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("fletcher32_byte_stream_checksum_core verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int short_total;
        int len;
        int fill;
        clear_sums();

        // Single-byte messages: no word, sums stay at their start value.
        queue_message(1, 8'h00);
        queue_message(1, 8'hff);
        // Two-byte messages at the extremes.
        queue_message(2, 8'h00);
        queue_message(2, 8'hff);
        // Trailing odd byte after one full word.
        queue_message(3, 8'hff);
        pending_bytes.push_back('{data: 8'h01, is_last: 1'b0});
        pending_bytes.push_back('{data: 8'h80, is_last: 1'b0});
        pending_bytes.push_back('{data: 8'h7f, is_last: 1'b1});
        queue_message(5, -1);

        // Random short messages, with some saturated and some all-zero ones.
        short_total = 0;
        while (short_total < SHORT_BYTES) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                              : $urandom_range(4, 40);
            if ($urandom_range(0, 5) == 0)
                fill = 8'hff;
            else if ($urandom_range(0, 9) == 0)
                fill = 8'h00;
            else
                fill = -1;
            queue_message(len, fill);
            short_total += len;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the queue to empty and every expected sum to come back.
        do
            @(posedge i_clk);
        while (pending_bytes.size() != 0 || i_valid || expected_sums.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_sums.size() == 0)
            $display("fletcher32_byte_stream_checksum_core verification clean");
        else
            $display("fletcher32_byte_stream_checksum_core verification failed");
        $finish;
    end

endmodule
